// ===== hdl/sss_pkg.sv =====
package sss_pkg;

  // Time counter width default
  localparam int TIME_BITS_DEF = 32;

  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W     = 8;
  localparam int IVL_W     = 16;

  // Request codes
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_STOP  = 2'd2;

  // Mode codes
  localparam logic [1:0] MODE_FREE  = 2'd0;
  localparam logic [1:0] MODE_LOOP  = 2'd1;
  localparam logic [1:0] MODE_SENSE = 2'd2;

  // Sequencer phase codes
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WAIT = 2'd1;
  localparam logic [1:0] PH_SEQ  = 2'd2;
  localparam logic [1:0] PH_FREE = 2'd3;

  // Train codes
  localparam logic [1:0] TR_FIRST = 2'd0;
  localparam logic [1:0] TR_S1    = 2'd1;
  localparam logic [1:0] TR_S2    = 2'd2;
  localparam logic [1:0] TR_S3    = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_S1       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_S2       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_S3       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PW       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COUPLING = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT   = 3'd6;

  // Register reset values
  localparam logic [1:0]       RST_MODE     = MODE_FREE;
  localparam logic [CFG_W-1:0] RST_S1       = 24'd328180;
  localparam logic [CFG_W-1:0] RST_S2       = 24'd250;
  localparam logic [CFG_W-1:0] RST_S3       = 24'd125;
  localparam logic [7:0]       RST_PW       = 8'd2;
  localparam logic [15:0]      RST_COUPLING = 16'd200;
  localparam logic [7:0]       RST_REPEAT   = 8'd1;

  // Result of scheduling the next stimulus
  typedef struct packed {
    logic             found;
    logic [1:0]       train_idx;
    logic [CNT_W-1:0] pulses_left;
    logic [CNT_W-1:0] repeats_left;
  } adv_t;

  function automatic logic [CNT_W-1:0] train_count(
    input logic [1:0]       tr,
    input logic [CNT_W-1:0] c1,
    input logic [CNT_W-1:0] c2,
    input logic [CNT_W-1:0] c3
  );
    logic [CNT_W-1:0] c;
    case (tr)
      TR_S1:   c = c1;
      TR_S2:   c = c2;
      TR_S3:   c = c3;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/sss_if.sv =====
interface sss_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic       sensed_beat;

  modport source (output valid, output req_type, output sensed_beat, input ready);
  modport sink (input valid, input req_type, input sensed_beat, output ready);
endinterface

interface sss_out_if;
  logic       valid;
  logic       ready;
  logic       stim_on;
  logic       running;
  logic [1:0] train;
  logic       done_res;

  modport source (output valid, output stim_on, output running, output train,
                  output done_res, input ready);
  modport sink (input valid, input stim_on, input running, input train,
                input done_res, output ready);
endinterface

// ===== hdl/sss_advance.sv =====
// Finds the next stimulus after a finished pulse: walks trains S1..S3,
// skipping empty ones, wrapping to S1 for further passes.
module sss_advance (
  input  logic [1:0]                   train_idx,
  input  logic [sss_pkg::CNT_W-1:0]    pulses_left,
  input  logic [sss_pkg::CNT_W-1:0]    repeats_left,
  input  logic [sss_pkg::CNT_W-1:0]    cnt_s1,
  input  logic [sss_pkg::CNT_W-1:0]    cnt_s2,
  input  logic [sss_pkg::CNT_W-1:0]    cnt_s3,
  output sss_pkg::adv_t                adv
);

  localparam int STEPS = 8;

  logic                       any_cnt;
  logic                       ended;
  logic                       found;
  logic [1:0]                 ti;
  logic [sss_pkg::CNT_W-1:0]  pl;
  logic [sss_pkg::CNT_W-1:0]  rl;

  assign any_cnt = (cnt_s1 | cnt_s2 | cnt_s3) != '0;

  always_comb begin
    ended = 1'b0;
    found = 1'b0;
    ti    = train_idx;
    pl    = pulses_left;
    rl    = repeats_left;
    for (int i = 0; i < STEPS; i++) begin
      if (!found && !ended) begin
        if (pl != '0) begin
          pl    = pl - sss_pkg::CNT_W'(1);
          found = 1'b1;
        end else if (ti != sss_pkg::TR_S3) begin
          ti = ti + 2'd1;
          pl = sss_pkg::train_count(ti, cnt_s1, cnt_s2, cnt_s3);
        end else if (rl > sss_pkg::CNT_W'(1) && any_cnt) begin
          rl = rl - sss_pkg::CNT_W'(1);
          ti = sss_pkg::TR_S1;
          pl = cnt_s1;
        end else begin
          ended = 1'b1;
        end
      end
    end
    adv.found        = found;
    adv.train_idx    = ti;
    adv.pulses_left  = pl;
    adv.repeats_left = rl;
  end

endmodule

// ===== hdl/s1_s2_s3_stimulus_sequencer_top.sv =====
// Channel | Dir | Payload                              | Transfer
// --------+-----+--------------------------------------+-------------------------
// in_ch   | in  | req_type, sensed_beat                | valid && ready
// out_ch  | out | stim_on, running, train, done_res    | valid && ready
// cfg_*   | in  | cfg_index, cfg_wdata                 | cfg_we (no stall)
//
// One item per cycle while out_ch is not stalled: each input transfer updates the
// sequencer state at its edge, and its status is captured in the output register
// at that same edge and offered on out_ch from the next cycle.
// in_ch.ready = output register empty or being drained; a stalled out_ch holds
// the input off, no other back-pressure exists.
// Reset (rst_n low, synchronous) returns the registers to their defaults, time
// to zero and the sequencer to idle.
module s1_s2_s3_stimulus_sequencer_top #(
  parameter int TIME_BITS = sss_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sss_in_if.sink                        in_ch,
  sss_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [sss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sss_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int CW = sss_pkg::CNT_W;
  localparam int IW = sss_pkg::IVL_W;

  // Configuration registers
  logic [1:0]              mode_r;
  logic [sss_pkg::CFG_W-1:0] s1_r, s2_r, s3_r;
  logic [7:0]              pw_r;
  logic [15:0]             coupling_r;
  logic [7:0]              repeat_r;

  // Sequencer state
  logic                 running_r, running_nxt;
  logic                 pulse_r, pulse_nxt;
  logic [1:0]           phase_r, phase_nxt;
  logic [1:0]           train_r, train_nxt;
  logic [CW-1:0]        pl_r, pl_nxt;
  logic [CW-1:0]        rl_r, rl_nxt;
  logic [TIME_BITS-1:0] time_r, time_nxt;
  logic [TIME_BITS-1:0] stim_t_r, stim_t_nxt;
  logic [TIME_BITS-1:0] end_t_r, end_t_nxt;
  logic                 done_nxt;

  // Output register
  logic       out_valid_r;
  logic       out_stim_r, out_run_r, out_done_r;
  logic [1:0] out_train_r;

  logic                 in_xfer;
  logic [TIME_BITS-1:0] stim_diff, end_diff;
  logic                 stim_due, end_due;
  logic [7:0]           width;
  logic [IW-1:0]        ivl;
  sss_pkg::adv_t        adv;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= sss_pkg::RST_MODE;
      s1_r       <= sss_pkg::RST_S1;
      s2_r       <= sss_pkg::RST_S2;
      s3_r       <= sss_pkg::RST_S3;
      pw_r       <= sss_pkg::RST_PW;
      coupling_r <= sss_pkg::RST_COUPLING;
      repeat_r   <= sss_pkg::RST_REPEAT;
    end else if (cfg_we) begin
      case (cfg_index)
        sss_pkg::CFG_MODE:     mode_r     <= cfg_wdata[1:0];
        sss_pkg::CFG_S1:       s1_r       <= cfg_wdata;
        sss_pkg::CFG_S2:       s2_r       <= cfg_wdata;
        sss_pkg::CFG_S3:       s3_r       <= cfg_wdata;
        sss_pkg::CFG_PW:       pw_r       <= cfg_wdata[7:0];
        sss_pkg::CFG_COUPLING: coupling_r <= cfg_wdata[15:0];
        sss_pkg::CFG_REPEAT:   repeat_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Wrapping time compare: target reached when (now - target) is "non-negative"
  assign stim_diff = time_r - stim_t_r;
  assign end_diff  = time_r - end_t_r;
  assign stim_due  = !stim_diff[TIME_BITS-1];
  assign end_due   = !end_diff[TIME_BITS-1];
  assign width     = (pw_r == '0) ? 8'd1 : pw_r;

  sss_advance u_adv (
    .train_idx    (train_r),
    .pulses_left  (pl_r),
    .repeats_left (rl_r),
    .cnt_s1       (s1_r[23:16]),
    .cnt_s2       (s2_r[23:16]),
    .cnt_s3       (s3_r[23:16]),
    .adv          (adv)
  );

  // Interval of the train the next stimulus belongs to
  always_comb begin
    case (adv.train_idx)
      sss_pkg::TR_S1: ivl = s1_r[IW-1:0];
      sss_pkg::TR_S2: ivl = s2_r[IW-1:0];
      sss_pkg::TR_S3: ivl = s3_r[IW-1:0];
      default:        ivl = '0;
    endcase
  end

  always_comb begin
    running_nxt = running_r;
    pulse_nxt   = pulse_r;
    phase_nxt   = phase_r;
    train_nxt   = train_r;
    pl_nxt      = pl_r;
    rl_nxt      = rl_r;
    time_nxt    = time_r;
    stim_t_nxt  = stim_t_r;
    end_t_nxt   = end_t_r;
    done_nxt    = 1'b0;
    case (in_ch.req_type)
      sss_pkg::REQ_START: begin
        // ignored mid-pulse and for the reserved mode
        if (!pulse_r && (mode_r inside {sss_pkg::MODE_FREE, sss_pkg::MODE_LOOP,
                                         sss_pkg::MODE_SENSE})) begin
          running_nxt = 1'b1;
          train_nxt   = sss_pkg::TR_FIRST;
          pl_nxt      = '0;
          rl_nxt      = CW'(1);
          stim_t_nxt  = time_r;
          case (mode_r)
            sss_pkg::MODE_FREE: phase_nxt = sss_pkg::PH_FREE;
            sss_pkg::MODE_LOOP: begin
              phase_nxt = sss_pkg::PH_SEQ;
              rl_nxt    = repeat_r;
            end
            default: phase_nxt = sss_pkg::PH_WAIT;
          endcase
        end
      end
      sss_pkg::REQ_STOP: begin
        running_nxt = 1'b0;
        pulse_nxt   = 1'b0;
        phase_nxt   = sss_pkg::PH_IDLE;
        train_nxt   = sss_pkg::TR_FIRST;
        pl_nxt      = '0;
        rl_nxt      = '0;
      end
      sss_pkg::REQ_TICK: begin
        if (phase_r == sss_pkg::PH_WAIT) begin
          if (in_ch.sensed_beat) begin
            stim_t_nxt = time_r + TIME_BITS'(coupling_r);
            phase_nxt  = sss_pkg::PH_SEQ;
          end
        end else if (phase_r inside {sss_pkg::PH_SEQ, sss_pkg::PH_FREE}) begin
          if (!pulse_r) begin
            if (stim_due) begin
              pulse_nxt = 1'b1;
              end_t_nxt = time_r + TIME_BITS'(width);
            end
          end else if (end_due) begin
            pulse_nxt = 1'b0;
            if (phase_r == sss_pkg::PH_FREE || !adv.found) begin
              // protocol complete
              running_nxt = 1'b0;
              phase_nxt   = sss_pkg::PH_IDLE;
              train_nxt   = sss_pkg::TR_FIRST;
              pl_nxt      = '0;
              rl_nxt      = '0;
              done_nxt    = 1'b1;
            end else begin
              train_nxt  = adv.train_idx;
              pl_nxt     = adv.pulses_left;
              rl_nxt     = adv.repeats_left;
              stim_t_nxt = stim_t_r + TIME_BITS'(ivl);
            end
          end
        end
        time_nxt = time_r + TIME_BITS'(1);
      end
      default: ;  // reserved request: status only
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      pulse_r   <= 1'b0;
      phase_r   <= sss_pkg::PH_IDLE;
      train_r   <= sss_pkg::TR_FIRST;
      pl_r      <= '0;
      rl_r      <= '0;
      time_r    <= '0;
      stim_t_r  <= '0;
      end_t_r   <= '0;
    end else if (in_xfer) begin
      running_r <= running_nxt;
      pulse_r   <= pulse_nxt;
      phase_r   <= phase_nxt;
      train_r   <= train_nxt;
      pl_r      <= pl_nxt;
      rl_r      <= rl_nxt;
      time_r    <= time_nxt;
      stim_t_r  <= stim_t_nxt;
      end_t_r   <= end_t_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_stim_r  <= pulse_nxt;
      out_run_r   <= running_nxt;
      out_train_r <= train_nxt;
      out_done_r  <= done_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.stim_on  = out_stim_r;
  assign out_ch.running  = out_run_r;
  assign out_ch.train    = out_train_r;
  assign out_ch.done_res = out_done_r;

  // A finished protocol reports no pulse and not running
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> !out_stim_r && !out_run_r)
    else $error("done reported with sequencer still active");

  // A pulse only exists inside a running protocol
  a_pulse_running: assert property (@(posedge clk) disable iff (!rst_n)
    pulse_r |-> running_r)
    else $error("pulse active while idle");

  // Idle phase and running flag agree
  a_phase_running: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == sss_pkg::PH_IDLE) == !running_r)
    else $error("phase and running flag disagree");

  // Only tick transfers move time
  a_time_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_ch.req_type != sss_pkg::REQ_TICK |=> $stable(time_r))
    else $error("time advanced on a non-tick request");

endmodule
